@@ src/fkch_pkg.sv @@
// ----------------------------------------------------------------------------
// fkch_pkg: shared types and constants for the flow key hash pipeline
// Holds the canonical tuple layout, the per-item hash state and the
// MurmurHash3 x86_32 constants.
// ----------------------------------------------------------------------------
package fkch_pkg;

  localparam logic [2:0]  Ipv4Code       = 3'd4;
  localparam int unsigned NumWords       = 10;  // nine key blocks plus the tail byte
  localparam int unsigned RoundsPerStage = 3;

  localparam logic [31:0] MurmurC1  = 32'hcc9e2d51;
  localparam logic [31:0] MurmurC2  = 32'h1b873593;
  localparam logic [31:0] RoundAdd  = 32'he6546b64;
  localparam logic [31:0] FmixC1    = 32'h85ebca6b;
  localparam logic [31:0] FmixC2    = 32'hc2b2ae35;
  localparam logic [31:0] KeyLength = 32'd37;

  typedef logic [31:0] word_t;
  typedef word_t [NumWords-1:0] kwords_t;

  typedef struct packed {
    logic        swapped;
    logic [63:0] low_hi;
    logic [63:0] low_lo;
    logic [63:0] high_hi;
    logic [63:0] high_lo;
    logic [15:0] low_port;
    logic [15:0] high_port;
    logic [7:0]  proto;
  } tuple_t;

  typedef struct packed {
    tuple_t  tup;
    word_t   h;
    kwords_t k;
  } hstate_t;

  function automatic word_t bswap32(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

@@ src/fkch_canon.sv @@
// ----------------------------------------------------------------------------
// fkch_canon: endpoint ordering stage
// Masks IPv4 addresses, compares the two endpoints and registers the tuple
// in canonical order.
// ----------------------------------------------------------------------------
module fkch_canon import fkch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [2:0]  ip_version_i,
  input  logic [63:0] first_addr_hi_i,
  input  logic [63:0] first_addr_lo_i,
  input  logic [63:0] second_addr_hi_i,
  input  logic [63:0] second_addr_lo_i,
  input  logic [15:0] first_port_i,
  input  logic [15:0] second_port_i,
  input  logic [7:0]  proto_number_i,
  output logic        valid_o,
  input  logic        ready_i,
  output tuple_t      tup_o
);

  logic        valid_q;
  tuple_t      tup_q, tup_d;
  logic        is_v4, swap;
  logic [63:0] a_hi, a_lo, b_hi, b_lo;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    is_v4 = (ip_version_i == Ipv4Code);
    a_hi  = is_v4 ? {first_addr_hi_i[63:32], 32'h0}  : first_addr_hi_i;
    a_lo  = is_v4 ? 64'h0 : first_addr_lo_i;
    b_hi  = is_v4 ? {second_addr_hi_i[63:32], 32'h0} : second_addr_hi_i;
    b_lo  = is_v4 ? 64'h0 : second_addr_lo_i;
    // equal endpoints count as unordered and take the swap path
    swap  = !({a_hi, a_lo, first_port_i} < {b_hi, b_lo, second_port_i});
    tup_d.swapped   = swap;
    tup_d.low_hi    = swap ? b_hi : a_hi;
    tup_d.low_lo    = swap ? b_lo : a_lo;
    tup_d.high_hi   = swap ? a_hi : b_hi;
    tup_d.high_lo   = swap ? a_lo : b_lo;
    tup_d.low_port  = swap ? second_port_i : first_port_i;
    tup_d.high_port = swap ? first_port_i : second_port_i;
    tup_d.proto     = proto_number_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tup_q <= tup_d;
    end
  end

  assign valid_o = valid_q;
  assign tup_o   = tup_q;

endmodule

@@ src/fkch_kmix.sv @@
// ----------------------------------------------------------------------------
// fkch_kmix: key block mixing
// Packs the canonical key into little-endian words and runs the per-block
// multiply, rotate, multiply in two register stages, all blocks in parallel.
// ----------------------------------------------------------------------------
module fkch_kmix import fkch_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  tuple_t  tup_i,
  output logic    valid_o,
  input  logic    ready_i,
  output hstate_t st_o
);

  logic    v1_q, v2_q;
  logic    rdy1, rdy2;
  tuple_t  tup1_q, tup2_q;
  kwords_t words, k1_d, k1_q, k2_d, k2_q;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    words[0] = bswap32(tup_i.low_hi[63:32]);
    words[1] = bswap32(tup_i.low_hi[31:0]);
    words[2] = bswap32(tup_i.low_lo[63:32]);
    words[3] = bswap32(tup_i.low_lo[31:0]);
    words[4] = bswap32(tup_i.high_hi[63:32]);
    words[5] = bswap32(tup_i.high_hi[31:0]);
    words[6] = bswap32(tup_i.high_lo[63:32]);
    words[7] = bswap32(tup_i.high_lo[31:0]);
    words[8] = {tup_i.high_port, tup_i.low_port};
    words[9] = {24'h0, tup_i.proto};
    for (int i = 0; i < NumWords; i++) begin
      k1_d[i] = words[i] * MurmurC1;
    end
  end

  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      k2_d[i] = {k1_q[i][16:0], k1_q[i][31:17]} * MurmurC2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) begin
      tup1_q <= tup_i;
      k1_q   <= k1_d;
    end
    if (v1_q && rdy2) begin
      tup2_q <= tup1_q;
      k2_q   <= k2_d;
    end
  end

  assign valid_o  = v2_q;
  assign st_o.tup = tup2_q;
  assign st_o.h   = '0;  // seed
  assign st_o.k   = k2_q;

endmodule

@@ src/fkch_hround.sv @@
// ----------------------------------------------------------------------------
// fkch_hround: hash accumulation stage
// Folds the three lowest mixed blocks into the running hash and shifts the
// remaining blocks down for the next stage.
// ----------------------------------------------------------------------------
module fkch_hround import fkch_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  hstate_t st_i,
  output logic    valid_o,
  input  logic    ready_i,
  output hstate_t st_o
);

  logic    valid_q;
  hstate_t st_q, st_d;
  word_t   h, r;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    h = st_i.h;
    r = '0;
    for (int j = 0; j < RoundsPerStage; j++) begin
      r = h ^ st_i.k[j];
      r = {r[18:0], r[31:19]};
      h = r + {r[29:0], 2'b00} + RoundAdd;
    end
    st_d.tup = st_i.tup;
    st_d.h   = h;
    for (int i = 0; i < NumWords; i++) begin
      if (i + RoundsPerStage < NumWords) begin
        st_d.k[i] = st_i.k[i + RoundsPerStage];
      end else begin
        st_d.k[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

@@ src/fkch_fmix.sv @@
// ----------------------------------------------------------------------------
// fkch_fmix: tail and finalization
// Applies the tail block and the length, then the avalanche mix over three
// register stages; the last one is the output register.
// ----------------------------------------------------------------------------
module fkch_fmix import fkch_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  hstate_t st_i,
  output logic    valid_o,
  input  logic    ready_i,
  output tuple_t  tup_o,
  output word_t   hash_o
);

  logic   va_q, vb_q, vc_q;
  logic   rdya, rdyb, rdyc;
  tuple_t tupa_q, tupb_q, tupc_q;
  word_t  t1, t2, ma_d, ma_q, x, mb_d, mb_q, hc_d, hc_q;

  assign rdyc    = !vc_q || ready_i;
  assign rdyb    = !vb_q || rdyc;
  assign rdya    = !va_q || rdyb;
  assign ready_o = rdya;

  always_comb begin
    t1   = st_i.h ^ st_i.k[0] ^ KeyLength;
    t2   = t1 ^ {16'h0, t1[31:16]};
    ma_d = t2 * FmixC1;
    x    = ma_q ^ {13'h0, ma_q[31:13]};
    mb_d = x * FmixC2;
    hc_d = mb_q ^ {16'h0, mb_q[31:16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdya) va_q <= valid_i;
      if (rdyb) vb_q <= va_q;
      if (rdyc) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdya) begin
      tupa_q <= st_i.tup;
      ma_q   <= ma_d;
    end
    if (va_q && rdyb) begin
      tupb_q <= tupa_q;
      mb_q   <= mb_d;
    end
    if (vb_q && rdyc) begin
      tupc_q <= tupb_q;
      hc_q   <= hc_d;
    end
  end

  assign valid_o = vc_q;
  assign tup_o   = tupc_q;
  assign hash_o  = hc_q;

endmodule

@@ src/flow_key_canonicalize_hash_top.sv @@
// ----------------------------------------------------------------------------
// flow_key_canonicalize_hash_top: canonical flow key and MurmurHash3 x86_32
// Orders the two endpoints of a five-tuple and hashes the 37-byte key.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | to block  | in_valid_i / in_ready_o | version, two addresses, ports,
//           |           |                         | protocol
//   out     | from block| out_valid_o/out_ready_i | swap flag, canonical tuple,
//           |           |                         | flow hash
//
// One item enters per cycle while the output does not stall; each accepted
// item passes through 1 ordering stage, 2 block-mix stages (one per multiply),
// 3 accumulation stages (three dependent hash rounds each) and 3 finalization
// stages (one per multiply, plus the output register).
// Reset clears only the stage valid bits; the pipeline is empty after it.
// Every stage has its own valid bit and ready term, so a stall at the output
// holds the full stages and lets bubbles upstream close up; items are never
// dropped or repeated.
// ----------------------------------------------------------------------------
module flow_key_canonicalize_hash_top import fkch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  ip_version_i,
  input  logic [63:0] first_addr_hi_i,
  input  logic [63:0] first_addr_lo_i,
  input  logic [63:0] second_addr_hi_i,
  input  logic [63:0] second_addr_lo_i,
  input  logic [15:0] first_port_i,
  input  logic [15:0] second_port_i,
  input  logic [7:0]  proto_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        swapped_o,
  output logic [63:0] low_addr_hi_o,
  output logic [63:0] low_addr_lo_o,
  output logic [63:0] high_addr_hi_o,
  output logic [63:0] high_addr_lo_o,
  output logic [15:0] low_port_o,
  output logic [15:0] high_port_o,
  output logic [7:0]  proto_out_o,
  output logic [31:0] flow_hash_o
);

  // stage links: canon -> kmix -> three rounds -> fmix
  logic    c_valid, c_ready;
  tuple_t  c_tup;
  logic    m_valid, m_ready;
  hstate_t m_st;
  logic    r0_valid, r0_ready, r1_valid, r1_ready, r2_valid, r2_ready;
  hstate_t r0_st, r1_st, r2_st;
  tuple_t  out_tup;
  word_t   out_hash;

  fkch_canon u_canon (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (in_valid_i),
    .ready_o          (in_ready_o),
    .ip_version_i     (ip_version_i),
    .first_addr_hi_i  (first_addr_hi_i),
    .first_addr_lo_i  (first_addr_lo_i),
    .second_addr_hi_i (second_addr_hi_i),
    .second_addr_lo_i (second_addr_lo_i),
    .first_port_i     (first_port_i),
    .second_port_i    (second_port_i),
    .proto_number_i   (proto_number_i),
    .valid_o          (c_valid),
    .ready_i          (c_ready),
    .tup_o            (c_tup)
  );

  fkch_kmix u_kmix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid),
    .ready_o (c_ready),
    .tup_i   (c_tup),
    .valid_o (m_valid),
    .ready_i (m_ready),
    .st_o    (m_st)
  );

  // blocks 0-2, 3-5 and 6-8; the tail block ends up in word 0
  fkch_hround u_round0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid),
    .ready_o (m_ready),
    .st_i    (m_st),
    .valid_o (r0_valid),
    .ready_i (r0_ready),
    .st_o    (r0_st)
  );

  fkch_hround u_round1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r0_valid),
    .ready_o (r0_ready),
    .st_i    (r0_st),
    .valid_o (r1_valid),
    .ready_i (r1_ready),
    .st_o    (r1_st)
  );

  fkch_hround u_round2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r1_valid),
    .ready_o (r1_ready),
    .st_i    (r1_st),
    .valid_o (r2_valid),
    .ready_i (r2_ready),
    .st_o    (r2_st)
  );

  fkch_fmix u_fmix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r2_valid),
    .ready_o (r2_ready),
    .st_i    (r2_st),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .tup_o   (out_tup),
    .hash_o  (out_hash)
  );

  assign swapped_o      = out_tup.swapped;
  assign low_addr_hi_o  = out_tup.low_hi;
  assign low_addr_lo_o  = out_tup.low_lo;
  assign high_addr_hi_o = out_tup.high_hi;
  assign high_addr_lo_o = out_tup.high_lo;
  assign low_port_o     = out_tup.low_port;
  assign high_port_o    = out_tup.high_port;
  assign proto_out_o    = out_tup.proto;
  assign flow_hash_o    = out_hash;

  // the delivered key is always in canonical order
  a_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({low_addr_hi_o, low_addr_lo_o, low_port_o} <=
                     {high_addr_hi_o, high_addr_lo_o, high_port_o}))
    else $error("canonical key out of order");

  // an unswapped key was already strictly ordered
  a_strict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !swapped_o) |-> ({low_addr_hi_o, low_addr_lo_o, low_port_o} <
                                     {high_addr_hi_o, high_addr_lo_o, high_port_o}))
    else $error("unswapped key not strictly ordered");

  // an empty output stage lets the whole pipeline advance
  a_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage is empty");

endmodule

@@ verif/flow_hash_checker.sv @@
// ----------------------------------------------------------------------------
// flow_hash_checker: scoreboard for the flow key canonicalize and hash block
// Watches both channels. Computes the canonical tuple and the MurmurHash3
// x86_32 key hash of every accepted input item, queues it, and compares
// each accepted result with the oldest queued prediction, field by field.
// ----------------------------------------------------------------------------
module flow_hash_checker import fkch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  ip_version_i,
  input  logic [63:0] first_addr_hi_i,
  input  logic [63:0] first_addr_lo_i,
  input  logic [63:0] second_addr_hi_i,
  input  logic [63:0] second_addr_lo_i,
  input  logic [15:0] first_port_i,
  input  logic [15:0] second_port_i,
  input  logic [7:0]  proto_number_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        swapped_i,
  input  logic [63:0] low_addr_hi_i,
  input  logic [63:0] low_addr_lo_i,
  input  logic [63:0] high_addr_hi_i,
  input  logic [63:0] high_addr_lo_i,
  input  logic [15:0] low_port_i,
  input  logic [15:0] high_port_i,
  input  logic [7:0]  proto_out_i,
  input  logic [31:0] flow_hash_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned MaxReported = 10;

  typedef struct packed {
    tuple_t      tup;
    logic [31:0] hash;
  } flow_result_t;

  flow_result_t expected_flows[$];
  int failures = 0;
  int waiting  = 0;

  assign fail_count_o = failures;
  assign pending_o    = waiting;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_block(input logic [31:0] k);
    logic [31:0] t;
    t = k * MurmurC1;
    t = rotl32(t, 15);
    return t * MurmurC2;
  endfunction

  function automatic flow_result_t predict_flow(
    input logic [2:0]  ver,
    input logic [63:0] a_hi,
    input logic [63:0] a_lo,
    input logic [63:0] b_hi,
    input logic [63:0] b_lo,
    input logic [15:0] a_port,
    input logic [15:0] b_port,
    input logic [7:0]  proto
  );
    flow_result_t res;
    logic [63:0]  lo_hi, lo_lo, hi_hi, hi_lo;
    logic [15:0]  lo_port, hi_port;
    logic         keep;
    logic [7:0]   key [0:36];
    logic [31:0]  h;
    lo_hi = a_hi;
    lo_lo = a_lo;
    hi_hi = b_hi;
    hi_lo = b_lo;
    // IPv4 keeps address bytes 0-3 only
    if (ver == Ipv4Code) begin
      lo_hi[31:0] = '0;
      lo_lo       = '0;
      hi_hi[31:0] = '0;
      hi_lo       = '0;
    end
    if (lo_hi != hi_hi) begin
      keep = lo_hi < hi_hi;
    end else if (lo_lo != hi_lo) begin
      keep = lo_lo < hi_lo;
    end else begin
      keep = a_port < b_port;
    end
    if (keep) begin
      lo_port = a_port;
      hi_port = b_port;
    end else begin
      {lo_hi, hi_hi} = {hi_hi, lo_hi};
      {lo_lo, hi_lo} = {hi_lo, lo_lo};
      lo_port = b_port;
      hi_port = a_port;
    end
    for (int i = 0; i < 8; i++) begin
      key[i]      = lo_hi[63 - 8*i -: 8];
      key[8 + i]  = lo_lo[63 - 8*i -: 8];
      key[16 + i] = hi_hi[63 - 8*i -: 8];
      key[24 + i] = hi_lo[63 - 8*i -: 8];
    end
    key[32] = lo_port[7:0];
    key[33] = lo_port[15:8];
    key[34] = hi_port[7:0];
    key[35] = hi_port[15:8];
    key[36] = proto;
    h = '0;
    for (int i = 0; i < 9; i++) begin
      h ^= scramble_block({key[4*i + 3], key[4*i + 2], key[4*i + 1], key[4*i]});
      h  = rotl32(h, 13);
      h  = h * 32'd5 + RoundAdd;
    end
    h ^= scramble_block({24'd0, key[36]});
    h ^= KeyLength;
    h ^= h >> 16;
    h  = h * FmixC1;
    h ^= h >> 13;
    h  = h * FmixC2;
    h ^= h >> 16;
    res.tup.swapped   = !keep;
    res.tup.low_hi    = lo_hi;
    res.tup.low_lo    = lo_lo;
    res.tup.high_hi   = hi_hi;
    res.tup.high_lo   = hi_lo;
    res.tup.low_port  = lo_port;
    res.tup.high_port = hi_port;
    res.tup.proto     = proto;
    res.hash          = h;
    return res;
  endfunction

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= MaxReported) begin
      $display("%s", msg);
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      log_failure($sformatf("%s mismatch: expected %h, got %h", field, want, got));
    end
  endtask

  always @(posedge clk_i) begin : watch_channels
    flow_result_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_flows.size() == 0) begin
          log_failure($sformatf("result with no item pending: hash %h", flow_hash_i));
        end else begin
          want = expected_flows.pop_front();
          check_field("swapped", want.tup.swapped, swapped_i);
          check_field("low_addr_hi", want.tup.low_hi, low_addr_hi_i);
          check_field("low_addr_lo", want.tup.low_lo, low_addr_lo_i);
          check_field("high_addr_hi", want.tup.high_hi, high_addr_hi_i);
          check_field("high_addr_lo", want.tup.high_lo, high_addr_lo_i);
          check_field("low_port", want.tup.low_port, low_port_i);
          check_field("high_port", want.tup.high_port, high_port_i);
          check_field("proto_out", want.tup.proto, proto_out_i);
          check_field("flow_hash", want.hash, flow_hash_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_flows.push_back(predict_flow(ip_version_i, first_addr_hi_i,
                                              first_addr_lo_i, second_addr_hi_i,
                                              second_addr_lo_i, first_port_i,
                                              second_port_i, proto_number_i));
      end
      waiting = expected_flows.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top for the flow key canonicalize and hash block
// Drives five-tuples into the block, first a directed set of corner cases,
// then random tuples biased toward equal addresses and ports, under three
// idle mixes and two long output stalls. A checker beside the block does
// all prediction and comparison; this module only gives the verdict.
// ----------------------------------------------------------------------------
module tb import fkch_pkg::*; ();

  localparam int unsigned ClockHalf   = 4;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned FlowsPerMix = 430;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  ip_version_i = '0;
  logic [63:0] first_addr_hi_i = '0;
  logic [63:0] first_addr_lo_i = '0;
  logic [63:0] second_addr_hi_i = '0;
  logic [63:0] second_addr_lo_i = '0;
  logic [15:0] first_port_i = '0;
  logic [15:0] second_port_i = '0;
  logic [7:0]  proto_number_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        swapped_o;
  logic [63:0] low_addr_hi_o;
  logic [63:0] low_addr_lo_o;
  logic [63:0] high_addr_hi_o;
  logic [63:0] high_addr_lo_o;
  logic [15:0] low_port_o;
  logic [15:0] high_port_o;
  logic [7:0]  proto_out_o;
  logic [31:0] flow_hash_o;

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int fail_count;
  int pending;

  always #ClockHalf clk_i = ~clk_i;

  flow_key_canonicalize_hash_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .ip_version_i     (ip_version_i),
    .first_addr_hi_i  (first_addr_hi_i),
    .first_addr_lo_i  (first_addr_lo_i),
    .second_addr_hi_i (second_addr_hi_i),
    .second_addr_lo_i (second_addr_lo_i),
    .first_port_i     (first_port_i),
    .second_port_i    (second_port_i),
    .proto_number_i   (proto_number_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .swapped_o        (swapped_o),
    .low_addr_hi_o    (low_addr_hi_o),
    .low_addr_lo_o    (low_addr_lo_o),
    .high_addr_hi_o   (high_addr_hi_o),
    .high_addr_lo_o   (high_addr_lo_o),
    .low_port_o       (low_port_o),
    .high_port_o      (high_port_o),
    .proto_out_o      (proto_out_o),
    .flow_hash_o      (flow_hash_o)
  );

  flow_hash_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .ip_version_i     (ip_version_i),
    .first_addr_hi_i  (first_addr_hi_i),
    .first_addr_lo_i  (first_addr_lo_i),
    .second_addr_hi_i (second_addr_hi_i),
    .second_addr_lo_i (second_addr_lo_i),
    .first_port_i     (first_port_i),
    .second_port_i    (second_port_i),
    .proto_number_i   (proto_number_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .swapped_i        (swapped_o),
    .low_addr_hi_i    (low_addr_hi_o),
    .low_addr_lo_i    (low_addr_lo_o),
    .high_addr_hi_i   (high_addr_hi_o),
    .high_addr_lo_i   (high_addr_lo_o),
    .low_port_i       (low_port_o),
    .high_port_i      (high_port_o),
    .proto_out_i      (proto_out_o),
    .flow_hash_i      (flow_hash_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Guard against a hung handshake: end the run once the cycle budget is gone.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output side. A pending hold request takes priority: drop ready for a
  // full stretch, counted here, so the pipeline fills and backs up into the
  // input. Otherwise idle at the current receiver rate.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left   = HoldCycles - 1;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one item: idle at the sender rate, then present the tuple at a
  // falling edge and hold it until a rising edge sees ready.
  task automatic send_flow(input logic [2:0] ver, input logic [63:0] a_hi,
                           input logic [63:0] a_lo, input logic [63:0] b_hi,
                           input logic [63:0] b_lo, input logic [15:0] a_port,
                           input logic [15:0] b_port, input logic [7:0] proto);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    ip_version_i     = ver;
    first_addr_hi_i  = a_hi;
    first_addr_lo_i  = a_lo;
    second_addr_hi_i = b_hi;
    second_addr_lo_i = b_lo;
    first_port_i     = a_port;
    second_port_i    = b_port;
    proto_number_i   = proto;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Mostly random 64-bit values, with the extremes mixed in.
  function automatic logic [63:0] pick64();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random tuple. Bias the second address toward the first so the address
  // tie and the port tie-break come up often, including IPv4 ties hidden
  // behind junk in the unused low address bytes.
  task automatic send_random_flow();
    logic [2:0]  ver;
    logic [63:0] a_hi, a_lo, b_hi, b_lo;
    logic [15:0] a_port, b_port;
    case ($urandom_range(9))
      0, 1, 2, 3: ver = Ipv4Code;
      4, 5, 6, 7: ver = 3'd6;
      default:    ver = 3'($urandom_range(7));
    endcase
    a_hi = pick64();
    a_lo = pick64();
    b_hi = pick64();
    b_lo = pick64();
    case ($urandom_range(9))
      5: begin
        b_hi = a_hi;
        b_lo = a_lo;
      end
      6:       b_hi = a_hi;
      7:       b_hi[63:32] = a_hi[63:32];
      8: begin
        b_hi = a_hi;
        b_lo = a_lo ^ (64'd1 << $urandom_range(63));
      end
      9:       b_hi = a_hi ^ (64'd1 << $urandom_range(63));
      default: ;
    endcase
    a_port = pick16();
    b_port = ($urandom_range(3) == 0) ? a_port : pick16();
    send_flow(ver, a_hi, a_lo, b_hi, b_lo, a_port, b_port, 8'($urandom));
  endtask

  initial begin
    // Hold reset low, then release it away from the rising edge.
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners, no idling on the input, mild back-pressure.
    tx_idle_pct = 0;
    rx_idle_pct = 30;
    // identical endpoints: counts as unordered, swap leaves values alone
    send_flow(3'd6, '0, '0, '0, '0, '0, '0, '0);
    send_flow(3'd6, '1, '1, '1, '1, '1, '1, '1);
    send_flow(Ipv4Code, '0, '0, '0, '0, 16'd80, 16'd80, 8'd6);
    // equal addresses, port decides both ways
    send_flow(3'd6, '1, '1, '1, '1, 16'd0, 16'hffff, 8'd17);
    send_flow(3'd6, '1, '1, '1, '1, 16'hffff, 16'd0, 8'd17);
    // upper bytes decide, with the top bit set on one side
    send_flow(3'd6, 64'h8000_0000_0000_0000, '0, 64'h7fff_ffff_ffff_ffff, '1,
              16'd1, 16'd2, 8'd255);
    send_flow(3'd6, 64'h7fff_ffff_ffff_ffff, '1, 64'h8000_0000_0000_0000, '0,
              16'd2, 16'd1, 8'd0);
    // upper bytes tie, lower bytes decide
    send_flow(3'd6, 64'h0123_4567_89ab_cdef, 64'h8000_0000_0000_0000,
              64'h0123_4567_89ab_cdef, 64'h7fff_ffff_ffff_ffff, 16'd5, 16'd4, 8'd58);
    send_flow(3'd6, 64'h0123_4567_89ab_cdef, 64'h0000_0000_0000_0001,
              64'h0123_4567_89ab_cdef, 64'h0000_0000_0000_0002, 16'd9, 16'd3, 8'd58);
    // IPv4: only the top four bytes count, junk below must be cleared
    send_flow(Ipv4Code, 64'hc0a8_0001_dead_beef, '1, 64'hc0a8_0001_0bad_f00d,
              64'h1234, 16'd443, 16'd1024, 8'd6);
    send_flow(Ipv4Code, 64'hc0a8_0001_dead_beef, '1, 64'hc0a8_0001_0bad_f00d,
              64'h1234, 16'd1024, 16'd443, 8'd6);
    send_flow(Ipv4Code, 64'h0a00_0002_ffff_ffff, '0, 64'h0a00_0001_0000_0000, '1,
              16'd53, 16'd53, 8'd17);
    send_flow(Ipv4Code, '1, '1, '0, '0, '1, '0, 8'd1);
    // every version code in turn; all but IPv4 are handled as IPv6
    for (int v = 0; v < 8; v++) begin
      send_flow(3'(v), 64'hc0a8_0001_0000_0001, 64'h5, 64'hc0a8_0001_0000_0000,
                64'h6, 16'h1234, 16'h4321, 8'(v));
    end
    send_flow(3'd7, '0, '1, '0, '0, 16'h8000, 16'h7fff, 8'h80);

    // Random mix one: sender idles a little, receiver a lot. Park the output
    // for a long stretch halfway through.
    tx_idle_pct = 24;
    rx_idle_pct = 78;
    for (int n = 0; n < FlowsPerMix; n++) begin
      if (n == FlowsPerMix / 2) begin
        hold_requests++;
      end
      send_random_flow();
    end

    // Pause the input until every result is back.
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);

    // Random mix two: roles reversed.
    tx_idle_pct = 78;
    rx_idle_pct = 24;
    for (int n = 0; n < FlowsPerMix; n++) begin
      send_random_flow();
    end

    // Random mix three: no idling at all, except one long output stall
    // while the input keeps pushing.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int n = 0; n < FlowsPerMix; n++) begin
      if (n == 40) begin
        hold_requests++;
      end
      send_random_flow();
    end

    // Drain: drop valid, wait for the last result, then give stray results
    // time to show up.
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/fkch_pkg.sv
src/fkch_canon.sv
src/fkch_kmix.sv
src/fkch_hround.sv
src/fkch_fmix.sv
src/flow_key_canonicalize_hash_top.sv
verif/flow_hash_checker.sv
verif/tb.sv
